/* sv/zsbw_pkg.sv */
// ============================================================================
// zsbw_pkg
// Shared codes and constants for the zlib stored-block wrapper.
// ============================================================================
package zsbw_pkg;

    // Input item kinds, carried on s_tuser
    localparam logic [1:0] KIND_START  = 2'd0;
    localparam logic [1:0] KIND_DATA   = 2'd1;
    localparam logic [1:0] KIND_FINISH = 2'd2;

    // zlib header (CMF, FLG) and stored-block header byte (BFINAL, BTYPE 00)
    localparam logic [7:0] ZLIB_CMF     = 8'h78;
    localparam logic [7:0] ZLIB_FLG     = 8'h01;
    localparam logic [7:0] STORED_FINAL = 8'h01;

    // Adler-32 modulus
    localparam logic [16:0] ADLER_MOD = 17'd65521;

    // Beat index of the last result for each emitting kind
    localparam logic [2:0] START_LAST_BEAT  = 3'd6;
    localparam logic [2:0] FINISH_LAST_BEAT = 3'd3;

endpackage

/* sv/zlib_stored_block_wrapper.sv */
// ============================================================================
// zlib_stored_block_wrapper
// Wraps a payload byte run as one uncompressed zlib stream with an Adler-32
// trailer, sent most significant byte first.
// ============================================================================
//
//  channel  dir  tdata                 tuser                  tlast
//  -------  ---  --------------------  ---------------------  -----------------
//  s_*      in   [7:0] data_byte       [1:0] kind             -
//  m_*      out  [7:0] out_byte        [0] length_error       run_last
//  cfg_*    in   [15:0] block_length   -                      -
//
//  A payload byte takes one cycle: it is accepted every cycle while the output
//  side keeps taking results. A start transaction is sent by the emit stage as
//  7 result beats, a finish transaction as 4; the beat counter of that stage
//  steps through them. Dropped bytes and unused kinds produce nothing. Sums and
//  counts update at acceptance. Reset clears the configuration, control and
//  running state with the Adler low sum at one; no clearing pass. The output
//  register holds its result under m_tready low while the emit stage keeps one item in waiting.
//
module zlib_stored_block_wrapper
(
    input  logic        clk,
    input  logic        rst_n,

    input  logic        cfg_wr_en,
    input  logic [15:0] cfg_wr_data,   // [15:0] block_length

    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,       // [7:0] data_byte
    input  logic [1:0]  s_tuser,       // [1:0] kind

    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [7:0]  m_tdata,       // [7:0] out_byte
    output logic        m_tlast,
    output logic        m_tuser        // [0] length_error
);

    // Configuration and running state
    logic [15:0] block_length_reg;
    logic [15:0] sum_low_reg,  sum_low_next;
    logic [15:0] sum_high_reg, sum_high_next;
    logic [16:0] bytes_seen_reg;
    logic        overflow_seen_reg;

    // Emit stage: one accepted item waiting to be sent as result beats
    logic        pend_valid_reg;
    logic [1:0]  pend_kind_reg;
    logic [31:0] pend_data_reg;
    logic        pend_err_reg;
    logic [2:0]  beat_reg;

    // Output register
    logic        m_tvalid_reg;
    logic [7:0]  m_tdata_reg;
    logic        m_tlast_reg;
    logic        m_tuser_reg;

    logic        out_free;
    logic        pend_last;
    logic        emit;
    logic        accept;
    logic        overrun;
    logic        len_err;
    logic [16:0] low_sum;
    logic [16:0] high_sum;
    logic [7:0]  beat_byte;

    assign out_free = !m_tvalid_reg || m_tready;
    assign emit     = pend_valid_reg && out_free;
    assign s_tready = !pend_valid_reg || (pend_last && out_free);
    assign accept   = s_tvalid && s_tready;

    assign overrun  = bytes_seen_reg >= {1'b0, block_length_reg};
    assign len_err  = overflow_seen_reg || (bytes_seen_reg != {1'b0, block_length_reg});

    // Adler-32 update: each partial sum stays below twice the modulus
    always_comb
    begin
        low_sum = {1'b0, sum_low_reg} + {9'd0, s_tdata};
        if (low_sum >= zsbw_pkg::ADLER_MOD)
        begin
            low_sum = low_sum - zsbw_pkg::ADLER_MOD;
        end
        sum_low_next = low_sum[15:0];
        high_sum = {1'b0, sum_high_reg} + {1'b0, sum_low_next};
        if (high_sum >= zsbw_pkg::ADLER_MOD)
        begin
            high_sum = high_sum - zsbw_pkg::ADLER_MOD;
        end
        sum_high_next = high_sum[15:0];
    end

    // Select the byte for the current beat
    always_comb
    begin
        beat_byte = 8'h00;
        pend_last = 1'b0;
        unique case (pend_kind_reg)
            zsbw_pkg::KIND_START:
            begin
                pend_last = (beat_reg == zsbw_pkg::START_LAST_BEAT);
                case (beat_reg)
                    3'd0:    beat_byte = zsbw_pkg::ZLIB_CMF;
                    3'd1:    beat_byte = zsbw_pkg::ZLIB_FLG;
                    3'd2:    beat_byte = zsbw_pkg::STORED_FINAL;
                    3'd3:    beat_byte = pend_data_reg[7:0];
                    3'd4:    beat_byte = pend_data_reg[15:8];
                    3'd5:    beat_byte = ~pend_data_reg[7:0];
                    default: beat_byte = ~pend_data_reg[15:8];
                endcase
            end
            zsbw_pkg::KIND_FINISH:
            begin
                pend_last = (beat_reg == zsbw_pkg::FINISH_LAST_BEAT);
                case (beat_reg[1:0])
                    2'd0:    beat_byte = pend_data_reg[31:24];
                    2'd1:    beat_byte = pend_data_reg[23:16];
                    2'd2:    beat_byte = pend_data_reg[15:8];
                    default: beat_byte = pend_data_reg[7:0];
                endcase
            end
            default:
            begin
                // payload byte passes through as a single beat
                pend_last = 1'b1;
                beat_byte = pend_data_reg[7:0];
            end
        endcase
    end

    // Configuration register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            block_length_reg <= 16'd0;
        end
        else if (cfg_wr_en)
        begin
            block_length_reg <= cfg_wr_data;
        end
    end

    // Running state, updated as each transaction is accepted
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sum_low_reg       <= 16'd1;
            sum_high_reg      <= 16'd0;
            bytes_seen_reg    <= 17'd0;
            overflow_seen_reg <= 1'b0;
        end
        else if (accept)
        begin
            case (s_tuser)
                zsbw_pkg::KIND_START:
                begin
                    sum_low_reg       <= 16'd1;
                    sum_high_reg      <= 16'd0;
                    bytes_seen_reg    <= 17'd0;
                    overflow_seen_reg <= 1'b0;
                end
                zsbw_pkg::KIND_DATA:
                begin
                    if (overrun)
                    begin
                        // drop the byte and remember it
                        overflow_seen_reg <= 1'b1;
                    end
                    else
                    begin
                        sum_low_reg    <= sum_low_next;
                        sum_high_reg   <= sum_high_next;
                        bytes_seen_reg <= bytes_seen_reg + 17'd1;
                    end
                end
                default:
                begin
                end
            endcase
        end
    end

    // Emit stage control; a new transaction replaces the finishing one
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pend_valid_reg <= 1'b0;
            beat_reg       <= 3'd0;
        end
        else if (accept)
        begin
            beat_reg <= 3'd0;
            case (s_tuser)
                zsbw_pkg::KIND_START:  pend_valid_reg <= 1'b1;
                zsbw_pkg::KIND_FINISH: pend_valid_reg <= 1'b1;
                zsbw_pkg::KIND_DATA:   pend_valid_reg <= !overrun;
                default:               pend_valid_reg <= 1'b0;
            endcase
        end
        else if (emit)
        begin
            beat_reg <= beat_reg + 3'd1;
            if (pend_last)
            begin
                pend_valid_reg <= 1'b0;
            end
        end
    end

    // Emit stage payload: snapshot of what the beats will carry
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            pend_kind_reg <= s_tuser;
            pend_err_reg  <= len_err;
            case (s_tuser)
                zsbw_pkg::KIND_START:  pend_data_reg <= {16'd0, block_length_reg};
                zsbw_pkg::KIND_FINISH: pend_data_reg <= {sum_high_reg, sum_low_reg};
                default:               pend_data_reg <= {24'd0, s_tdata};
            endcase
        end
    end

    // Output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_tvalid_reg <= 1'b0;
        end
        else if (out_free)
        begin
            m_tvalid_reg <= pend_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (emit)
        begin
            m_tdata_reg <= beat_byte;
            m_tlast_reg <= pend_last;
            m_tuser_reg <= pend_last && (pend_kind_reg == zsbw_pkg::KIND_FINISH)
                           && pend_err_reg;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tlast  = m_tlast_reg;
    assign m_tuser  = m_tuser_reg;

endmodule

/* tb/testbench.sv */
`timescale 1ns / 100ps
// ============================================================================
// testbench: zlib stored-block wrapper
// Drives start, payload, finish and unused-kind transactions with random
// gaps and output stalls. A predictor of the header, pass-through and Adler-32
// trailer checks every output transaction field by field, in order.
// ============================================================================
module testbench;

    localparam logic [1:0] KIND_UNUSED = 2'd3;
    localparam int         CYCLE_LIMIT = 400000;
    localparam int         ITEM_TARGET = 320;

    typedef struct {
        logic [7:0] out_byte;
        logic       run_last;
        logic       len_err;
    } zlib_beat_t;

    // optional typed value for the last result of one transaction
    typedef struct {
        bit         en;
        logic [7:0] tbyte;
        logic       terr;
    } typed_last_t;

    typedef struct {
        bit          set_len;
        logic [15:0] len;
        logic [1:0]  kind;
        logic [7:0]  data;
        typed_last_t tag;
    } stim_row_t;

    logic        clk;
    logic        rst_n;
    logic        cfg_wr_en   = 1'b0;
    logic [15:0] cfg_wr_data = 16'd0;
    logic        s_tvalid    = 1'b0;
    logic        s_tready;
    logic [7:0]  s_tdata     = 8'd0;
    logic [1:0]  s_tuser     = 2'd0;
    logic        m_tvalid;
    logic        m_tready    = 1'b0;
    logic [7:0]  m_tdata;
    logic        m_tlast;
    logic        m_tuser;

    // predictor state
    logic [15:0] cur_block_len;
    logic [15:0] adler_lo;
    logic [15:0] adler_hi;
    logic [16:0] payload_count;
    logic        byte_dropped;

    zlib_beat_t  zlib_bytes_due[$];
    typed_last_t typed_last_q[$];
    stim_row_t   dir_rows[$];

    bit quiet = 1'b0;
    int errors = 0;
    int cycles = 0;
    int items_in = 0;
    int beats_out = 0;
    int blocks_run = 0;
    int rdy_hold = 0;

    zlib_stored_block_wrapper uut
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .s_tuser     (s_tuser),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .m_tlast     (m_tlast),
        .m_tuser     (m_tuser)
    );

    initial
    begin
        clk = 1'b0;
    end

    always #6 clk = ~clk;

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("end of test: mismatches");
            $finish;
        end
    end

    function automatic zlib_beat_t mk_beat(logic [7:0] b, logic l, logic e);
        zlib_beat_t r;
        r.out_byte = b;
        r.run_last = l;
        r.len_err  = e;
        return r;
    endfunction

    // Expected stream bytes for one accepted transaction
    task automatic predict_zlib_bytes(input logic [1:0] kind, input logic [7:0] data);
        logic [7:0]  lo;
        logic [7:0]  hi;
        int unsigned acc;
        logic        err;
        begin
            lo = cur_block_len[7:0];
            hi = cur_block_len[15:8];
            case (kind)
                zsbw_pkg::KIND_START:
                begin
                    adler_lo      = 16'd1;
                    adler_hi      = 16'd0;
                    payload_count = 17'd0;
                    byte_dropped  = 1'b0;
                    zlib_bytes_due.push_back(mk_beat(zsbw_pkg::ZLIB_CMF, 1'b0, 1'b0));
                    zlib_bytes_due.push_back(mk_beat(zsbw_pkg::ZLIB_FLG, 1'b0, 1'b0));
                    zlib_bytes_due.push_back(mk_beat(zsbw_pkg::STORED_FINAL, 1'b0, 1'b0));
                    zlib_bytes_due.push_back(mk_beat(lo, 1'b0, 1'b0));
                    zlib_bytes_due.push_back(mk_beat(hi, 1'b0, 1'b0));
                    zlib_bytes_due.push_back(mk_beat(~lo, 1'b0, 1'b0));
                    zlib_bytes_due.push_back(mk_beat(~hi, 1'b1, 1'b0));
                end
                zsbw_pkg::KIND_DATA:
                begin
                    if (payload_count >= {1'b0, cur_block_len})
                        byte_dropped = 1'b1;
                    else
                    begin
                        acc = (adler_lo + data) % 65521;
                        adler_lo = acc[15:0];
                        acc = (adler_hi + adler_lo) % 65521;
                        adler_hi = acc[15:0];
                        payload_count = payload_count + 17'd1;
                        zlib_bytes_due.push_back(mk_beat(data, 1'b1, 1'b0));
                    end
                end
                zsbw_pkg::KIND_FINISH:
                begin
                    err = byte_dropped || (payload_count != {1'b0, cur_block_len});
                    zlib_bytes_due.push_back(mk_beat(adler_hi[15:8], 1'b0, 1'b0));
                    zlib_bytes_due.push_back(mk_beat(adler_hi[7:0], 1'b0, 1'b0));
                    zlib_bytes_due.push_back(mk_beat(adler_lo[15:8], 1'b0, 1'b0));
                    zlib_bytes_due.push_back(mk_beat(adler_lo[7:0], 1'b1, err));
                end
                default:
                begin
                end
            endcase
        end
    endtask

    // Monitor: track config, predict on input transactions, check outputs
    always @(posedge clk)
    begin : monitor
        typed_last_t tg;
        zlib_beat_t  got;
        zlib_beat_t  want;
        int          n0;
        if (!rst_n)
        begin
            cur_block_len = 16'd0;
            adler_lo      = 16'd1;
            adler_hi      = 16'd0;
            payload_count = 17'd0;
            byte_dropped  = 1'b0;
        end
        else
        begin
            if (cfg_wr_en)
                cur_block_len = cfg_wr_data;
            if (s_tvalid && s_tready)
            begin
                tg = typed_last_q.pop_front();
                n0 = zlib_bytes_due.size();
                predict_zlib_bytes(s_tuser, s_tdata);
                // replace the last predicted result with the typed value
                if (tg.en && zlib_bytes_due.size() > n0)
                begin
                    zlib_bytes_due[$].out_byte = tg.tbyte;
                    zlib_bytes_due[$].len_err  = tg.terr;
                end
                items_in++;
            end
            if (m_tvalid && m_tready)
            begin
                got = mk_beat(m_tdata, m_tlast, m_tuser);
                beats_out++;
                if (zlib_bytes_due.size() == 0)
                begin
                    $error("unexpected output transaction: out_byte %h", got.out_byte);
                    errors++;
                end
                else
                begin
                    want = zlib_bytes_due.pop_front();
                    if (got.out_byte !== want.out_byte)
                    begin
                        $error("out_byte: expected %h, actual %h", want.out_byte, got.out_byte);
                        errors++;
                    end
                    if (got.run_last !== want.run_last)
                    begin
                        $error("run_last: expected %b, actual %b", want.run_last, got.run_last);
                        errors++;
                    end
                    if (got.len_err !== want.len_err)
                    begin
                        $error("length_error: expected %b, actual %b", want.len_err, got.len_err);
                        errors++;
                    end
                end
            end
        end
    end

    // Output side: stall in random bursts
    always @(posedge clk)
    begin
        if (quiet)
            m_tready <= 1'b1;
        else if (rdy_hold > 0)
        begin
            rdy_hold <= rdy_hold - 1;
            m_tready <= 1'b0;
        end
        else if ($urandom_range(0, 7) == 0)
        begin
            rdy_hold <= $urandom_range(0, 14);
            m_tready <= 1'b0;
        end
        else
            m_tready <= 1'b1;
    end

    function automatic typed_last_t mk_tag(bit en, logic [7:0] b, logic e);
        typed_last_t t;
        t.en    = en;
        t.tbyte = b;
        t.terr  = e;
        return t;
    endfunction

    task automatic add_row(input bit set_len, input logic [15:0] len, input logic [1:0] kind,
                           input logic [7:0] data, input typed_last_t tag);
        stim_row_t r;
        begin
            r.set_len = set_len;
            r.len     = len;
            r.kind    = kind;
            r.data    = data;
            r.tag     = tag;
            dir_rows.push_back(r);
        end
    endtask

    task automatic send_item(input logic [1:0] kind, input logic [7:0] data,
                             input typed_last_t tag);
        int gap;
        begin
            if (!quiet && $urandom_range(0, 4) == 0)
            begin
                gap = $urandom_range(1, 15);
                s_tvalid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            typed_last_q.push_back(tag);
            s_tvalid <= 1'b1;
            s_tuser  <= kind;
            s_tdata  <= data;
            @(posedge clk);
            while (!s_tready) @(posedge clk);
        end
    endtask

    // Drop valid and wait until every expected byte has come out
    task automatic settle_stream();
        begin
            s_tvalid <= 1'b0;
            @(posedge clk);
            while (zlib_bytes_due.size() != 0) @(posedge clk);
            // let a dropped byte or unused kind clear the pipe
            repeat (6) @(posedge clk);
        end
    endtask

    task automatic load_block_length(input logic [15:0] len);
        begin
            settle_stream();
            cfg_wr_en   <= 1'b1;
            cfg_wr_data <= len;
            @(posedge clk);
            cfg_wr_en   <= 1'b0;
        end
    endtask

    initial
    begin : stimulus
        typed_last_t no_tag;
        stim_row_t   row;
        int          sent;
        int          len;
        int          nbytes;
        int          mode;
        bit          wrap_block;
        logic [7:0]  d;

        no_tag = mk_tag(1'b0, 8'h00, 1'b0);
        rst_n = 1'b0;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // trailer from reset state, drop with zero length, error trailer
        add_row(1'b0, 16'd0, zsbw_pkg::KIND_FINISH, 8'h00, mk_tag(1'b1, 8'h01, 1'b0));
        add_row(1'b0, 16'd0, zsbw_pkg::KIND_DATA, 8'hAB, no_tag);
        add_row(1'b0, 16'd0, zsbw_pkg::KIND_FINISH, 8'h00, mk_tag(1'b1, 8'h01, 1'b1));
        // short block with extreme bytes
        add_row(1'b1, 16'd3, zsbw_pkg::KIND_START, 8'h00, mk_tag(1'b1, 8'hFF, 1'b0));
        add_row(1'b0, 16'd0, zsbw_pkg::KIND_DATA, 8'h00, no_tag);
        add_row(1'b0, 16'd0, zsbw_pkg::KIND_DATA, 8'hFF, no_tag);
        add_row(1'b0, 16'd0, zsbw_pkg::KIND_DATA, 8'h80, no_tag);
        add_row(1'b0, 16'd0, zsbw_pkg::KIND_FINISH, 8'h00, no_tag);
        // unused kind, byte after finish, repeated trailer
        add_row(1'b0, 16'd0, KIND_UNUSED, 8'h55, no_tag);
        add_row(1'b0, 16'd0, KIND_UNUSED, 8'hFF, no_tag);
        add_row(1'b0, 16'd0, zsbw_pkg::KIND_DATA, 8'h11, no_tag);
        add_row(1'b0, 16'd0, zsbw_pkg::KIND_FINISH, 8'h00, no_tag);
        // maximum length, short count
        add_row(1'b1, 16'hFFFF, zsbw_pkg::KIND_START, 8'h00, mk_tag(1'b1, 8'h00, 1'b0));
        add_row(1'b0, 16'd0, zsbw_pkg::KIND_DATA, 8'hFF, no_tag);
        add_row(1'b0, 16'd0, zsbw_pkg::KIND_DATA, 8'hFF, no_tag);
        add_row(1'b0, 16'd0, zsbw_pkg::KIND_DATA, 8'hFF, no_tag);
        add_row(1'b0, 16'd0, zsbw_pkg::KIND_FINISH, 8'h00, no_tag);
        // length changed mid-block
        add_row(1'b1, 16'd2, zsbw_pkg::KIND_START, 8'h00, no_tag);
        add_row(1'b0, 16'd0, zsbw_pkg::KIND_DATA, 8'h5A, no_tag);
        add_row(1'b1, 16'd1, zsbw_pkg::KIND_FINISH, 8'h00, no_tag);
        add_row(1'b0, 16'd0, zsbw_pkg::KIND_DATA, 8'h3C, no_tag);
        add_row(1'b0, 16'd0, zsbw_pkg::KIND_FINISH, 8'h00, no_tag);
        // empty block against length one
        add_row(1'b0, 16'd0, zsbw_pkg::KIND_START, 8'h00, mk_tag(1'b1, 8'hFF, 1'b0));
        add_row(1'b0, 16'd0, zsbw_pkg::KIND_FINISH, 8'h00, mk_tag(1'b1, 8'h01, 1'b1));

        foreach (dir_rows[i])
        begin
            row = dir_rows[i];
            if (row.set_len)
                load_block_length(row.len);
            send_item(row.kind, row.data, row.tag);
        end

        // random blocks: mostly well formed, some broken or noisy
        sent = 0;
        while (sent < ITEM_TARGET)
        begin
            wrap_block = (blocks_run == 2);
            case ($urandom_range(0, 9))
                0: len = 0;
                1: len = 16'hFFFF;
                default: len = $urandom_range(1, 24);
            endcase
            if (wrap_block)
                len = 270;
            load_block_length(len[15:0]);
            mode = wrap_block ? 0 : $urandom_range(0, 9);
            if (mode != 8)
            begin
                send_item(zsbw_pkg::KIND_START, 8'($urandom_range(0, 255)), no_tag);
                sent++;
            end
            nbytes = (len == 16'hFFFF) ? $urandom_range(1, 30) : len;
            if (mode == 7)
                nbytes = ($urandom_range(0, 1) && nbytes > 0) ? nbytes - 1
                                                             : nbytes + $urandom_range(1, 3);
            for (int k = 0; k < nbytes; k++)
            begin
                // bias toward 0xFF so the low sum wraps past the modulus
                if (wrap_block || $urandom_range(0, 7) == 0)
                    d = 8'hFF;
                else
                    d = 8'($urandom_range(0, 255));
                if (mode == 9 && $urandom_range(0, 3) == 0)
                    send_item(KIND_UNUSED, 8'($urandom_range(0, 255)), no_tag);
                send_item(zsbw_pkg::KIND_DATA, d, no_tag);
                sent++;
            end
            send_item(zsbw_pkg::KIND_FINISH, 8'($urandom_range(0, 255)), no_tag);
            sent++;
            if ($urandom_range(0, 7) == 0)
            begin
                send_item(zsbw_pkg::KIND_FINISH, 8'($urandom_range(0, 255)), no_tag);
                sent++;
            end
            blocks_run++;
            if (sent > (ITEM_TARGET * 85) / 100)
                quiet = 1'b1;
        end

        settle_stream();
        repeat (20) @(posedge clk);
        $display("Covered %0d input and %0d output transactions over %0d random blocks,",
                 items_in, beats_out, blocks_run);
        $display("including drops, unused kinds, repeated trailers and length extremes.");
        if (errors == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

endmodule
